>>> rtl/mbpc_pkg.sv
package mbpc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SETTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAP      = 2'd3;

  localparam logic [15:0] RST_RELEASE_SETTLE = 16'd50;
  localparam logic [15:0] RST_SHORT_PRESS    = 16'd200;
  localparam logic [15:0] RST_LONG_PRESS     = 16'd2000;
  localparam logic [15:0] RST_PRESS_CAP      = 16'd5000;

  localparam logic [15:0] TIME_MAX  = 16'hFFFF;
  localparam logic [3:0]  COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HELD  = 2'd1,
    MODE_SHORT = 2'd2,
    MODE_LONG  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic [7:0]  levels_pressed;
  } in_beat_t;

  typedef struct packed {
    logic       event_valid;
    logic [2:0] event_button;
    logic       event_long;
    logic [3:0] held_total;
    logic [3:0] pending_count;
    logic       fast_poll;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] release_settle_ms;
    logic [15:0] short_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] press_time_cap_ms;
  } cfg_t;

  typedef struct packed {
    logic        last_level;
    mode_e       mode;
    logic [15:0] press_time;
    logic [15:0] release_time;
    logic [15:0] longest_press;
  } btn_state_t;

endpackage

>>> rtl/mbpc_btn_unit.sv
module mbpc_btn_unit
  import mbpc_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic        level_i,
  input  logic [15:0] dt_i,
  input  btn_state_t  cur_i,
  output btn_state_t  nxt_o
);

  logic [16:0] press_sum;
  logic [16:0] release_sum;
  logic [15:0] release_sat;

  assign press_sum   = {1'b0, cur_i.press_time} + {1'b0, dt_i};
  assign release_sum = {1'b0, cur_i.release_time} + {1'b0, dt_i};
  assign release_sat = release_sum[16] ? TIME_MAX : release_sum[15:0];

  always_comb begin
    nxt_o = cur_i;
    nxt_o.last_level = level_i;
    if (level_i) begin
      if (cur_i.last_level) begin
        nxt_o.press_time = (press_sum < {1'b0, cfg_i.press_time_cap_ms}) ?
                           press_sum[15:0] : cfg_i.press_time_cap_ms;
      end else begin
        nxt_o.release_time = '0;
        nxt_o.press_time   = '0;
        nxt_o.mode         = MODE_HELD;
      end
    end else if (cur_i.last_level) begin
      if (cur_i.press_time > cur_i.longest_press) begin
        nxt_o.longest_press = cur_i.press_time;
      end
      nxt_o.press_time = '0;
    end else if (cur_i.mode == MODE_HELD) begin
      nxt_o.release_time = release_sat;
      if (release_sat >= cfg_i.release_settle_ms) begin
        if (cur_i.longest_press >= cfg_i.long_press_ms) begin
          nxt_o.mode = MODE_LONG;
        end else if (cur_i.longest_press >= cfg_i.short_press_ms) begin
          nxt_o.mode = MODE_SHORT;
        end else begin
          nxt_o.mode = MODE_IDLE;
        end
      end
    end
  end

endmodule

>>> rtl/multi_button_press_classifier_core.sv
// Poll-tick classifier for short and long button presses.
// The input channel carries one beat per poll tick: the milliseconds since
// the previous tick and the sampled level of each of the first eight buttons.
// Buttons at index eight and above always read as released.
// The output channel returns exactly one beat per input beat, holding the
// reported press event, the held and pending counts and the fast poll hint.
// A shared per-button update unit visits one button per cycle, and the
// block takes no new input beat until the result of the previous beat
// has been loaded into the output register.
// The input stall is high while a beat is being processed.
// A finished result sits in an output register; while the receiver stalls,
// the next beat can still be accepted and scanned, and only its final
// load waits until the output register is free.
// Reset clears all button state and loads the default thresholds.
// The configuration port is a plain write port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module multi_button_press_classifier_core
  import mbpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o
);

  localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BUTTONS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  cfg_t       cfg_q;
  seq_state_e state_q, state_d;
  in_beat_t   beat_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] held_q, pend_q;
  logic [IDX_W-1:0] last_q;
  logic             last_long_q;
  logic             out_valid_q;
  out_beat_t        out_q;

  btn_state_t btn_q [NUM_BUTTONS];
  btn_state_t cur_btn, nxt_btn;
  logic [NUM_BUTTONS-1:0] levels;

  logic in_fire, scan_en, out_free, done_fire;
  logic [3:0] held_sat, pend_sat;

  assign levels  = NUM_BUTTONS'(beat_q.levels_pressed);
  assign cur_btn = btn_q[idx_q];

  mbpc_btn_unit u_btn (
    .cfg_i   (cfg_q),
    .level_i (levels[idx_q]),
    .dt_i    (beat_q.elapsed_ms),
    .cur_i   (cur_btn),
    .nxt_o   (nxt_btn)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (idx_q == LAST_IDX) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    scan_en    = 1'b0;
    done_fire  = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN: scan_en = 1'b1;
      ST_DONE: done_fire = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign held_sat = (32'(held_q) > 32'(COUNT_MAX)) ? COUNT_MAX : 4'(held_q);
  assign pend_sat = (32'(pend_q) > 32'(COUNT_MAX)) ? COUNT_MAX : 4'(pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_settle_ms <= RST_RELEASE_SETTLE;
      cfg_q.short_press_ms    <= RST_SHORT_PRESS;
      cfg_q.long_press_ms     <= RST_LONG_PRESS;
      cfg_q.press_time_cap_ms <= RST_PRESS_CAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RELEASE_SETTLE: cfg_q.release_settle_ms <= cfg_wdata_i;
        CFG_SHORT_PRESS:    cfg_q.short_press_ms    <= cfg_wdata_i;
        CFG_LONG_PRESS:     cfg_q.long_press_ms     <= cfg_wdata_i;
        CFG_PRESS_CAP:      cfg_q.press_time_cap_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      held_q      <= '0;
      pend_q      <= '0;
      last_q      <= '0;
      last_long_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        idx_q       <= '0;
        held_q      <= '0;
        pend_q      <= '0;
        last_q      <= '0;
        last_long_q <= 1'b0;
      end else if (scan_en) begin
        idx_q <= idx_q + 1'b1;
        if (nxt_btn.mode == MODE_HELD) begin
          held_q <= held_q + 1'b1;
        end
        if (nxt_btn.mode == MODE_SHORT || nxt_btn.mode == MODE_LONG) begin
          pend_q      <= pend_q + 1'b1;
          last_q      <= idx_q;
          last_long_q <= (nxt_btn.mode == MODE_LONG);
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      beat_q <= in_data_i;
    end
    if (done_fire) begin
      out_q.held_total    <= held_sat;
      out_q.pending_count <= pend_sat;
      out_q.fast_poll     <= (held_q != '0) || (pend_q != '0);
      if (held_q == '0 && pend_q == CNT_W'(1)) begin
        out_q.event_valid  <= 1'b1;
        out_q.event_button <= 3'(last_q);
        out_q.event_long   <= last_long_q;
      end else begin
        out_q.event_valid  <= 1'b0;
        out_q.event_button <= '0;
        out_q.event_long   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_q[i] <= '{last_level: 1'b0, mode: MODE_IDLE, press_time: '0,
                      release_time: '0, longest_press: '0};
      end
    end else if (scan_en) begin
      btn_q[idx_q] <= nxt_btn;
    end else if (done_fire && held_q == '0) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (btn_q[i].mode == MODE_SHORT || btn_q[i].mode == MODE_LONG) begin
          btn_q[i].mode          <= MODE_IDLE;
          btn_q[i].longest_press <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/mbpc_checker.sv
module mbpc_checker
  import mbpc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_beat_t             out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input accepted while a beat is in progress.");

  a_event_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_valid |->
      out_data_o.held_total == 4'd0 && out_data_o.pending_count == 4'd1)
    else $error("Event reported without exactly one pending press.");

  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.event_valid |->
      out_data_o.event_button == 3'd0 && !out_data_o.event_long)
    else $error("Event fields set without an event.");

  a_fast_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fast_poll ==
      (out_data_o.held_total != 4'd0 || out_data_o.pending_count != 4'd0))
    else $error("Fast poll hint disagrees with the counts.");

endmodule

bind multi_button_press_classifier_core mbpc_checker u_mbpc_checker (.*);
